/* sv/iuff_pkg.sv */
// shared types and constants for the ipv4/udp frame header filter
// no dependencies; imported by every module of the block
package iuff_pkg;

    // frame byte counter saturates here; the count width follows the fixed field width
    localparam int unsigned MAX_FRAME_BYTES = 65535;
    localparam int unsigned COUNT_W         = 16;

    // byte offsets of the captured header fields
    localparam logic [COUNT_W-1:0] POS_ETYPE_HI = 16'd12;
    localparam logic [COUNT_W-1:0] POS_ETYPE_LO = 16'd13;
    localparam logic [COUNT_W-1:0] POS_VER_IHL  = 16'd14;
    localparam logic [COUNT_W-1:0] POS_FRAG_HI  = 16'd20;
    localparam logic [COUNT_W-1:0] POS_FRAG_LO  = 16'd21;
    localparam logic [COUNT_W-1:0] POS_PROTO    = 16'd23;
    localparam logic [COUNT_W-1:0] POS_UDPLEN_HI = 16'd38;
    localparam logic [COUNT_W-1:0] POS_UDPLEN_LO = 16'd39;

    // minimum lengths for each header level
    localparam logic [COUNT_W-1:0] ETH_HDR_BYTES   = 16'd14;
    localparam logic [COUNT_W-1:0] IP_END_BYTES    = 16'd34;
    localparam logic [COUNT_W-1:0] UDPLEN_END_BYTES = 16'd40;
    localparam logic [COUNT_W-1:0] UDP_END_BYTES   = 16'd42;

    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4     = 4'd4;
    localparam logic [3:0]  IP_IHL_5         = 4'd5;
    localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1FFF;
    localparam logic [15:0] FRAG_MF_MASK     = 16'h2000;
    localparam logic [7:0]  IP_PROTO_UDP     = 8'd17;
    localparam logic [15:0] UDP_MIN_LEN      = 16'd8;
    localparam logic [5:0]  PAYLOAD_OFFSET   = 6'd42;

    typedef enum logic [2:0] {
        VERDICT_ACCEPT   = 3'd0,
        VERDICT_SHORT    = 3'd1,
        VERDICT_ETYPE    = 3'd2,
        VERDICT_VER_IHL  = 3'd3,
        VERDICT_FRAGMENT = 3'd4,
        VERDICT_NOT_UDP  = 3'd5,
        VERDICT_UDP_SMALL = 3'd6,
        VERDICT_OVERRUN  = 3'd7
    } t_verdict;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_verdict          verdict;
        logic [15:0]       frame_length;
        logic [15:0]       udp_length;
        logic [5:0]        payload_offset;
    } t_out_item;

    // header fields as they stand once the current byte is taken in
    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic [15:0]        ether_type;
        logic [7:0]         version_ihl;
        logic [15:0]        fragment_word;
        logic [7:0]         ip_protocol;
        logic [15:0]        udp_len_field;
    } t_hdr_fields;

endpackage

/* sv/iuff_capture.sv */
// byte counter and header field capture at fixed frame offsets
// depends on iuff_pkg
module iuff_capture import iuff_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_in_item    i_item,
    output t_hdr_fields o_hdr
);

    t_hdr_fields r_hdr;
    t_hdr_fields n_hdr;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_FRAME_BYTES);

    always_comb begin
        n_hdr = r_hdr;
        if (r_hdr.byte_count < COUNT_MAX) begin
            case (r_hdr.byte_count)
                POS_ETYPE_HI:  n_hdr.ether_type[15:8]    = i_item.data_byte;
                POS_ETYPE_LO:  n_hdr.ether_type[7:0]     = i_item.data_byte;
                POS_VER_IHL:   n_hdr.version_ihl         = i_item.data_byte;
                POS_FRAG_HI:   n_hdr.fragment_word[15:8] = i_item.data_byte;
                POS_FRAG_LO:   n_hdr.fragment_word[7:0]  = i_item.data_byte;
                POS_PROTO:     n_hdr.ip_protocol         = i_item.data_byte;
                POS_UDPLEN_HI: n_hdr.udp_len_field[15:8] = i_item.data_byte;
                POS_UDPLEN_LO: n_hdr.udp_len_field[7:0]  = i_item.data_byte;
                default: begin
                end
            endcase
            n_hdr.byte_count = r_hdr.byte_count + COUNT_W'(1);
        end
    end

    assign o_hdr = n_hdr;

    // cleared after the final byte so the next frame starts fresh
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= '0;
        end else if (i_step) begin
            if (i_item.last_byte) begin
                r_hdr <= '0;
            end else begin
                r_hdr <= n_hdr;
            end
        end
    end

endmodule

/* sv/iuff_judge.sv */
// verdict logic over the captured header fields, first failing check wins
// depends on iuff_pkg
module iuff_judge import iuff_pkg::*; (
    input  t_hdr_fields i_hdr,
    output t_out_item   o_result
);

    logic [COUNT_W-1:0] len;
    logic [16:0]        udp_end;
    t_verdict           verdict;

    assign len     = i_hdr.byte_count;
    assign udp_end = {1'b0, i_hdr.udp_len_field} + {1'b0, IP_END_BYTES};

    always_comb begin
        if (len < ETH_HDR_BYTES) begin
            verdict = VERDICT_SHORT;
        end else if (i_hdr.ether_type != ETHERTYPE_IPV4) begin
            verdict = VERDICT_ETYPE;
        end else if (len < IP_END_BYTES) begin
            verdict = VERDICT_SHORT;
        end else if (i_hdr.version_ihl[7:4] != IP_VERSION_4
                     || i_hdr.version_ihl[3:0] != IP_IHL_5) begin
            verdict = VERDICT_VER_IHL;
        end else if ((i_hdr.fragment_word & (FRAG_OFFSET_MASK | FRAG_MF_MASK)) != 16'd0) begin
            verdict = VERDICT_FRAGMENT;
        end else if (i_hdr.ip_protocol != IP_PROTO_UDP) begin
            verdict = VERDICT_NOT_UDP;
        end else if (len < UDP_END_BYTES) begin
            verdict = VERDICT_SHORT;
        end else if (i_hdr.udp_len_field < UDP_MIN_LEN) begin
            verdict = VERDICT_UDP_SMALL;
        end else if (udp_end > {1'b0, len}) begin
            verdict = VERDICT_OVERRUN;
        end else begin
            verdict = VERDICT_ACCEPT;
        end
    end

    always_comb begin
        o_result.verdict        = verdict;
        o_result.frame_length   = len;
        o_result.udp_length     = (len >= UDPLEN_END_BYTES) ? i_hdr.udp_len_field : 16'd0;
        o_result.payload_offset = (verdict == VERDICT_ACCEPT) ? PAYLOAD_OFFSET : 6'd0;
    end

endmodule

/* sv/ipv4_udp_frame_filter.sv */
// top level of the ipv4/udp header filter: input register, capture, verdict, output register
// depends on iuff_pkg, iuff_capture, iuff_judge
// a verdict is registered in the output register and shown on o_valid once its final byte leaves the input register
// throughput: one byte per cycle except while o_stall is high; bytes keep flowing while a verdict waits on the output
// a final byte holds in the input register only while the output register is full and stalled
// reset (i_rst_n low, synchronous) empties both registers and clears the captured header
module ipv4_udp_frame_filter import iuff_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    // input register
    logic        r_in_valid;
    t_in_item    r_in_data;

    // output register
    logic        r_out_valid;
    t_out_item   r_out_data;

    logic        out_blocked;
    logic        in_advance;
    t_hdr_fields hdr;
    t_out_item   result;

    // output register cannot take a new verdict this cycle
    assign out_blocked = r_out_valid && i_stall;

    // a mid-frame byte produces no verdict, so it never waits for the output side
    assign in_advance = r_in_valid && (!r_in_data.last_byte || !out_blocked);

    // input side stalls only when the held byte cannot move on
    assign o_stall = r_in_valid && !in_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_data <= i_data;
        end
    end

    // header capture, advanced once per byte leaving the input register
    iuff_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_advance),
        .i_item  (r_in_data),
        .o_hdr   (hdr)
    );

    // verdict over the fields including the current byte
    iuff_judge u_judge (
        .i_hdr    (hdr),
        .o_result (result)
    );

    // output register loads on the transfer of a final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_out_valid <= in_advance && r_in_data.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!out_blocked && in_advance && r_in_data.last_byte) begin
            r_out_data <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

`ifndef NO_ASSERTIONS
    // a final byte that leaves the input register always yields a verdict next cycle
    a_last_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_advance && r_in_data.last_byte) |=> r_out_valid)
        else $error("final byte transfer produced no verdict");

    // payload offset reported only for an accepted frame
    a_offset_matches_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_data.verdict == VERDICT_ACCEPT)
                         == (r_out_data.payload_offset == PAYLOAD_OFFSET)))
        else $error("payload offset disagrees with verdict");

    // an accepted frame holds at least the full udp header
    a_accept_long_enough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.verdict == VERDICT_ACCEPT)
            |-> (r_out_data.frame_length >= UDP_END_BYTES))
        else $error("accepted frame shorter than the udp header");

    // udp length field only reported once the frame reached it
    a_udp_len_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.frame_length < UDPLEN_END_BYTES)
            |-> (r_out_data.udp_length == 16'd0))
        else $error("udp length reported for a frame that never reached it");
`endif

endmodule
